[hdl/adcsc_pkg.sv]
// package for the ad-census stereo matching cost block
// register codes, reset values, widths and the exp rom builders
// no dependencies
package adcsc_pkg;

  localparam int CENSUS_BITS_DEF = 48;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_TAU_COLOR    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAU_GRAD     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_LEVEL = 4'd3;

  localparam logic [7:0] TAU_COLOR_RST    = 8'd7;
  localparam logic [8:0] TAU_GRAD_RST     = 9'd2;
  localparam logic [8:0] ALPHA_RST        = 9'd28;
  localparam logic [7:0] BORDER_LEVEL_RST = 8'd0;

  localparam int GROM_LEN = 1024;
  localparam int CROM_LEN = 49;
  localparam int GIDX_W   = 10;
  localparam int CIDX_W   = 6;

  localparam logic [63:0] RATIO_G = 64'd4223977731;
  localparam logic [63:0] RATIO_C = 64'd4173990425;
  localparam logic [63:0] ONE_Q15 = 64'd32767;
  localparam logic [15:0] TWO_Q15 = 16'd65534;

  typedef logic [15:0] grom_t [GROM_LEN];
  typedef logic [15:0] crom_t [CROM_LEN];

  function automatic logic [15:0] rom_entry(input logic [63:0] v);
    logic [63:0] t;
    t = (v * ONE_Q15 + (64'd1 << 30)) >> 31;
    return t[15:0];
  endfunction

  function automatic logic [63:0] rom_next(input logic [63:0] v, input logic [63:0] ratio);
    return (v * ratio + (64'd1 << 31)) >> 32;
  endfunction

  function automatic grom_t gen_grom();
    grom_t rom;
    logic [63:0] v;
    v = 64'd1 << 31;
    for (int k = 0; k < GROM_LEN; k++) begin
      rom[k] = rom_entry(v);
      v = rom_next(v, RATIO_G);
    end
    return rom;
  endfunction

  function automatic crom_t gen_crom();
    crom_t rom;
    logic [63:0] v;
    v = 64'd1 << 31;
    for (int k = 0; k < CROM_LEN; k++) begin
      rom[k] = rom_entry(v);
      v = rom_next(v, RATIO_C);
    end
    return rom;
  endfunction

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[hdl/ad_census_stereo_cost.sv]
// ad-census matching cost for one stereo pixel pair per transaction
// eight-stage pipeline: abs differences, truncation, blend, rom index, exp roms
// depends on adcsc_pkg
//
// One transaction is accepted per clock while in_stall is low. Its cost is
// carried by the eight pipeline registers, the first of which is loaded at
// the accepting edge and the last two of which are the registered exp rom
// read and the final subtract.
// in_stall rises only when every stage holds an item and out_stall holds
// the result. Configuration writes always complete (cfg_ready is high) and
// should be made while no transaction is in flight.
module ad_census_stereo_cost
  import adcsc_pkg::*;
#(
  parameter int CENSUS_BITS = CENSUS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_left_red,
  input  logic [7:0]            in_left_green,
  input  logic [7:0]            in_left_blue,
  input  logic [7:0]            in_right_red,
  input  logic [7:0]            in_right_green,
  input  logic [7:0]            in_right_blue,
  input  logic signed [9:0]     in_left_grad,
  input  logic signed [9:0]     in_right_grad,
  input  logic [47:0]           in_left_census,
  input  logic [47:0]           in_right_census,
  input  logic                  in_in_range,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_cost,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG  = 8;
  localparam int NCHK  = (CENSUS_BITS + 7) / 8;
  localparam int CNT_W = $clog2(CENSUS_BITS + 1);
  localparam logic [47:0] CMASK = 48'((49'd1 << CENSUS_BITS) - 49'd1);
  localparam grom_t GROM = gen_grom();
  localparam crom_t CROM = gen_crom();

  // configuration
  logic [7:0] tau_color_r;
  logic [8:0] tau_grad_r;
  logic [8:0] alpha_r;
  logic [7:0] border_level_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_color_r    <= TAU_COLOR_RST;
      tau_grad_r     <= TAU_GRAD_RST;
      alpha_r        <= ALPHA_RST;
      border_level_r <= BORDER_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TAU_COLOR:    tau_color_r    <= cfg_data[7:0];
        REG_TAU_GRAD:     tau_grad_r     <= cfg_data;
        REG_ALPHA:        alpha_r        <= cfg_data;
        REG_BORDER_LEVEL: border_level_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] go;

  always_comb begin
    go[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  assign in_stall  = !go[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (go[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 0: input register
  logic [7:0]        lr_r, lgr_r, lb_r, rr_r, rgr_r, rb_r;
  logic signed [9:0] lgd_r, rgd_r;
  logic [47:0]       lcen_r, rcen_r;
  logic              inr0_r;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      lr_r   <= in_left_red;
      lgr_r  <= in_left_green;
      lb_r   <= in_left_blue;
      rr_r   <= in_right_red;
      rgr_r  <= in_right_green;
      rb_r   <= in_right_blue;
      lgd_r  <= in_left_grad;
      rgd_r  <= in_right_grad;
      lcen_r <= in_left_census;
      rcen_r <= in_right_census;
      inr0_r <= in_in_range;
    end
  end

  // stage 1: colour sum, gradient difference, census partial counts
  logic [7:0]         sr_c, sg_c, sb_c;
  logic signed [9:0]  sgrad_c;
  logic signed [10:0] gd_c;
  logic [9:0]         gabs_c;
  logic [9:0]         sum_c;
  logic [47:0]        cx_c;
  logic [3:0]         chk_c [NCHK];

  logic [9:0] sum1_r;
  logic [9:0] gabs1_r;
  logic [3:0] chk1_r [NCHK];
  logic       inr1_r;

  always_comb begin
    sr_c    = inr0_r ? rr_r  : border_level_r;
    sg_c    = inr0_r ? rgr_r : border_level_r;
    sb_c    = inr0_r ? rb_r  : border_level_r;
    sgrad_c = inr0_r ? rgd_r : $signed({2'b00, border_level_r});
    sum_c   = 10'(absdiff8(lr_r, sr_c)) + 10'(absdiff8(lgr_r, sg_c))
            + 10'(absdiff8(lb_r, sb_c));
    gd_c    = {lgd_r[9], lgd_r} - {sgrad_c[9], sgrad_c};
    gabs_c  = gd_c[10] ? 10'(-gd_c) : gd_c[9:0];
    cx_c    = (lcen_r ^ rcen_r) & CMASK;
    for (int c = 0; c < NCHK; c++) begin
      chk_c[c] = '0;
      for (int b = 0; b < 8; b++) begin
        chk_c[c] = chk_c[c] + 4'(cx_c[c*8+b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      sum1_r  <= sum_c;
      gabs1_r <= gabs_c;
      chk1_r  <= chk_c;
      inr1_r  <= inr0_r;
    end
  end

  // stage 2: truncation, alpha clamp, hamming distance
  logic [9:0]       tc3_c;
  logic [CNT_W-1:0] ham_c;

  logic [9:0]       c3_2_r;
  logic [8:0]       g2_r;
  logic [8:0]       a2_r;
  logic [8:0]       am2_r;
  logic [CNT_W-1:0] n2_r;

  always_comb begin
    tc3_c = {1'b0, tau_color_r, 1'b0} + {2'b00, tau_color_r};
    ham_c = '0;
    for (int c = 0; c < NCHK; c++) begin
      ham_c = ham_c + CNT_W'(chk1_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      c3_2_r <= (sum1_r < tc3_c) ? sum1_r : tc3_c;
      g2_r   <= (gabs1_r > {1'b0, tau_grad_r}) ? tau_grad_r : gabs1_r[8:0];
      a2_r   <= (alpha_r > 9'd256) ? 9'd256 : alpha_r;
      am2_r  <= 9'd256 - ((alpha_r > 9'd256) ? 9'd256 : alpha_r);
      n2_r   <= inr1_r ? ham_c : CNT_W'(CENSUS_BITS);
    end
  end

  // stage 3: blend products
  logic [18:0]      pc3_r;
  logic [17:0]      pg3_r;
  logic [CNT_W-1:0] n3_r;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      pc3_r <= 19'(a2_r) * 19'(c3_2_r);
      pg3_r <= 18'(am2_r) * 18'(g2_r);
      n3_r  <= n2_r;
    end
  end

  // stage 4: blended sum, rounding offset, divide by 64
  logic [19:0]      b_c;
  logic [13:0]      x4_r;
  logic [CNT_W-1:0] n4_r;

  assign b_c = 20'(pc3_r) + 20'({pg3_r, 1'b0}) + 20'(pg3_r) + 20'd96;

  always_ff @(posedge clk) begin
    if (go[4]) begin
      x4_r <= b_c[19:6];
      n4_r <= n3_r;
    end
  end

  // stage 5: divide by three with saturation at the last rom entry
  logic [26:0]       qm_c;
  logic [GIDX_W-1:0] q5_r;
  logic [CIDX_W-1:0] n5_r;

  assign qm_c = 27'(x4_r[11:0]) * 27'd10923;

  always_ff @(posedge clk) begin
    if (go[5]) begin
      q5_r <= (x4_r >= 14'd3072) ? GIDX_W'(GROM_LEN - 1) : qm_c[24:15];
      n5_r <= CIDX_W'(n4_r);
    end
  end

  // stage 6: exp rom reads
  logic [15:0] gent6_r;
  logic [15:0] cent6_r;

  always_ff @(posedge clk) begin
    if (go[6]) begin
      gent6_r <= GROM[q5_r];
      cent6_r <= CROM[n5_r];
    end
  end

  // stage 7: output register
  logic [15:0] cost_r;

  always_ff @(posedge clk) begin
    if (go[7]) begin
      cost_r <= TWO_Q15 - cent6_r - gent6_r;
    end
  end

  assign out_cost = cost_r;

  // assertions
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&vld_r)))
    else $error("input stalled while the pipeline has room");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transaction lost at the input register");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !vld_r[NSTG-2]) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

[dv/ad_census_stereo_cost_tb.sv]
// testbench for ad_census_stereo_cost: bursty pixel-pair traffic, random output stalls
// a scoreboard class predicts each cost from the register settings and checks results in order
// depends on adcsc_pkg and the ad_census_stereo_cost rtl
module ad_census_stereo_cost_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adcsc_pkg::*;

  localparam int N_DIRECTED = 16;
  localparam int HOLD_CYCLES = 90;

  typedef struct {
    logic [7:0]        l_red, l_green, l_blue;
    logic [7:0]        r_red, r_green, r_blue;
    logic signed [9:0] l_grad, r_grad;
    logic [47:0]       l_census, r_census;
    logic              in_range;
  } pixel_pair_t;

  class cost_scoreboard;
    logic [7:0]  tau_color;
    logic [8:0]  tau_grad;
    logic [8:0]  alpha;
    logic [7:0]  border_level;
    logic [15:0] grad_exp [GROM_LEN];
    logic [15:0] census_exp [CROM_LEN];
    logic [15:0] cost_q [$];
    int          errors;

    function new();
      logic [63:0] vg, vc;
      tau_color    = TAU_COLOR_RST;
      tau_grad     = TAU_GRAD_RST;
      alpha        = ALPHA_RST;
      border_level = BORDER_LEVEL_RST;
      errors       = 0;
      vg = 64'd1 << 31;
      vc = 64'd1 << 31;
      for (int k = 0; k < GROM_LEN; k++) begin
        grad_exp[k] = q15(vg);
        vg = (vg * RATIO_G + (64'd1 << 31)) >> 32;
        if (k < CROM_LEN) begin
          census_exp[k] = q15(vc);
          vc = (vc * RATIO_C + (64'd1 << 31)) >> 32;
        end
      end
    endfunction

    function logic [15:0] q15(logic [63:0] v);
      logic [63:0] t;
      t = (v * 64'd32767 + (64'd1 << 30)) >> 31;
      return t[15:0];
    endfunction

    function int absd(int x, int y);
      return (x > y) ? x - y : y - x;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_TAU_COLOR:    tau_color = d[7:0];
        REG_TAU_GRAD:     tau_grad = d;
        REG_ALPHA:        alpha = d;
        REG_BORDER_LEVEL: border_level = d[7:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] cost_of(pixel_pair_t p);
      int lc [3];
      int rc [3];
      int lgr, rgr, s, c3, tc3, g, a, b, q, n, tg;
      lc[0] = p.l_red;
      lc[1] = p.l_green;
      lc[2] = p.l_blue;
      lgr = p.l_grad;
      if (p.in_range) begin
        rc[0] = p.r_red;
        rc[1] = p.r_green;
        rc[2] = p.r_blue;
        rgr = p.r_grad;
        n = $countones(p.l_census ^ p.r_census);
      end else begin
        for (int i = 0; i < 3; i++) rc[i] = border_level;
        rgr = border_level;
        n = CENSUS_BITS_DEF;
      end
      s = 0;
      for (int i = 0; i < 3; i++) s += absd(lc[i], rc[i]);
      tc3 = 3 * int'(tau_color);
      c3 = (s < tc3) ? s : tc3;
      tg = tau_grad;
      g = absd(lgr, rgr);
      if (g > tg) g = tg;
      a = (int'(alpha) > 256) ? 256 : int'(alpha);
      b = a * c3 + 3 * (256 - a) * g;
      q = (b + 96) / 192;
      if (q > GROM_LEN - 1) q = GROM_LEN - 1;
      if (n > CROM_LEN - 1) n = CROM_LEN - 1;
      return 16'(TWO_Q15 - census_exp[n] - grad_exp[q]);
    endfunction

    function void note_pair(pixel_pair_t p);
      cost_q.push_back(cost_of(p));
    endfunction

    function void check_cost(logic [15:0] got);
      logic [15:0] want;
      if (cost_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("cost %0d arrived with no transaction pending", got);
        return;
      end
      want = cost_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("cost mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return cost_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_left_red = '0;
  logic [7:0]            in_left_green = '0;
  logic [7:0]            in_left_blue = '0;
  logic [7:0]            in_right_red = '0;
  logic [7:0]            in_right_green = '0;
  logic [7:0]            in_right_blue = '0;
  logic signed [9:0]     in_left_grad = '0;
  logic signed [9:0]     in_right_grad = '0;
  logic [47:0]           in_left_census = '0;
  logic [47:0]           in_right_census = '0;
  logic                  in_in_range = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           out_cost;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit hold_req = 1'b0;
  cost_scoreboard sb = new();

  ad_census_stereo_cost dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_red     (in_left_red),
    .in_left_green   (in_left_green),
    .in_left_blue    (in_left_blue),
    .in_right_red    (in_right_red),
    .in_right_green  (in_right_green),
    .in_right_blue   (in_right_blue),
    .in_left_grad    (in_left_grad),
    .in_right_grad   (in_right_grad),
    .in_left_census  (in_left_census),
    .in_right_census (in_right_census),
    .in_in_range     (in_in_range),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cost        (out_cost),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : watch
    pixel_pair_t seen;
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (rst_n && in_valid && !in_stall) begin
      seen.l_red    = in_left_red;
      seen.l_green  = in_left_green;
      seen.l_blue   = in_left_blue;
      seen.r_red    = in_right_red;
      seen.r_green  = in_right_green;
      seen.r_blue   = in_right_blue;
      seen.l_grad   = in_left_grad;
      seen.r_grad   = in_right_grad;
      seen.l_census = in_left_census;
      seen.r_census = in_right_census;
      seen.in_range = in_in_range;
      sb.note_pair(seen);
    end
    if (rst_n && out_valid && !out_stall) sb.check_cost(out_cost);
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver
    int stall_mode, mode_left, hold_left, tick;
    stall_mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (tick % 3 == 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] near8(logic [7:0] v, int d);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * d)) - d;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic pixel_pair_t rand_pair();
    pixel_pair_t p;
    int kind, d, t;
    logic [47:0] flips;
    kind = $urandom_range(0, 9);
    d = $urandom_range(0, 12);
    p.l_red    = $urandom_range(0, 255);
    p.l_green  = $urandom_range(0, 255);
    p.l_blue   = $urandom_range(0, 255);
    p.l_grad   = 10'(int'($urandom_range(0, 511)) - 128);
    p.l_census = rand48();
    p.in_range = (kind < 8);
    flips = rand48() & rand48() & rand48();
    if (kind < 5) begin
      p.r_red   = near8(p.l_red, d);
      p.r_green = near8(p.l_green, d);
      p.r_blue  = near8(p.l_blue, d);
      t = int'(p.l_grad) + int'($urandom_range(0, 2 * d)) - d;
      if (t < -128) t = -128;
      if (t > 383) t = 383;
      p.r_grad = 10'(t);
      case ($urandom_range(0, 2))
        0: p.r_census = p.l_census ^ flips;
        1: p.r_census = ~p.l_census ^ flips;
        default: p.r_census = rand48();
      endcase
    end else begin
      p.r_red    = $urandom_range(0, 255);
      p.r_green  = $urandom_range(0, 255);
      p.r_blue   = $urandom_range(0, 255);
      p.r_grad   = 10'(int'($urandom_range(0, 511)) - 128);
      p.r_census = rand48();
    end
    return p;
  endfunction

  function automatic pixel_pair_t directed_pair(int k);
    pixel_pair_t p;
    p = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 10'sd0, 10'sd0, 48'd0, 48'd0, 1'b1};
    case (k)
      1: p = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 10'sd383, 10'sd383,
               '1, '1, 1'b1};
      2: p = '{8'hff, 8'hff, 8'hff, 8'd0, 8'd0, 8'd0, 10'sd383, -10'sd128,
               '1, 48'd0, 1'b1};
      3: p = '{8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff, -10'sd128, 10'sd383,
               48'd0, '1, 1'b1};
      4: p.r_census = 48'd1;
      5: p.r_census = 48'h8000_0000_0000;
      6: begin
        p.l_grad = 10'sd10;
        p.r_grad = 10'sd12;
      end
      7: begin
        p.l_grad = 10'sd10;
        p.r_grad = 10'sd13;
      end
      8: p = '{8'd10, 8'd10, 8'd10, 8'd17, 8'd17, 8'd17, 10'sd0, 10'sd0,
               48'd0, 48'd0, 1'b1};
      9: p = '{8'd10, 8'd10, 8'd10, 8'd17, 8'd17, 8'd18, 10'sd0, 10'sd0,
               48'd0, 48'd0, 1'b1};
      10: p = '{8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 10'sd341, 10'sd170,
                48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 1'b1};
      11: p = '{8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff, 10'sd0, 10'sd383,
                48'h1234_5678_9abc, '1, 1'b0};
      12: p = '{8'hff, 8'hff, 8'hff, 8'd3, 8'd9, 8'd27, 10'sd383, -10'sd128,
                '1, 48'd0, 1'b0};
      13: p = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, -10'sd128, -10'sd128,
                48'd0, 48'd0, 1'b0};
      14: p = '{8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff, 10'sd0, 10'sd0,
                48'h0f0f_0f0f_0f0f, 48'h0f0f_0f0f_0f0f, 1'b1};
      15: begin
        p.l_grad = -10'sd1;
        p.r_grad = 10'sd0;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic drive_pair(input pixel_pair_t p);
    in_valid        <= 1'b1;
    in_left_red     <= p.l_red;
    in_left_green   <= p.l_green;
    in_left_blue    <= p.l_blue;
    in_right_red    <= p.r_red;
    in_right_green  <= p.r_green;
    in_right_blue   <= p.r_blue;
    in_left_grad    <= p.l_grad;
    in_right_grad   <= p.r_grad;
    in_left_census  <= p.l_census;
    in_right_census <= p.r_census;
    in_in_range     <= p.in_range;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [8:0] tc, input logic [8:0] tg,
                          input logic [8:0] al, input logic [8:0] bl);
    go_idle();
    repeat (10) @(posedge clk);
    write_cfg(REG_TAU_COLOR, tc);
    write_cfg(REG_TAU_GRAD, tg);
    write_cfg(REG_ALPHA, al);
    write_cfg(REG_BORDER_LEVEL, bl);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit squeeze);
    int sent, burst, gap;
    sent = 0;
    // receiver holds off while a back-to-back run fills the pipeline
    if (squeeze) begin
      hold_req = 1'b1;
      repeat (24) begin
        drive_pair(rand_pair());
        sent++;
      end
    end
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < count) begin
          drive_pair(rand_pair());
          sent++;
          if (sent == count / 2) go_idle();
        end
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < N_DIRECTED; k++) drive_pair(directed_pair(k));
    run_random(300, 1'b1);
    set_regs(9'd255, 9'd511, 9'd256, 9'd255);
    run_random(300, 1'b0);
    set_regs(9'd0, 9'd0, 9'd0, 9'd0);
    run_random(250, 1'b0);
    set_regs(9'd255, 9'd511, 9'd511, 9'd128);
    run_random(250, 1'b1);
    repeat (3) begin
      set_regs(9'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
               9'($urandom_range(0, 300)), 9'($urandom_range(0, 255)));
      run_random(230, 1'b0);
    end
    go_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
